### rtl/core/assert_macros.svh
// assertion helpers used by stq_seq
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every edge outside reset
`define ASSERT_IMPL(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);

// implication with the right side checked in the cycle after the left side
`define ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

### rtl/core/stq_pkg.sv
package stq_pkg;

   localparam int TableDepth = 16;
   localparam int IdxW = $clog2(TableDepth);
   localparam int CntW = $clog2(TableDepth + 1);
   localparam int EntryW = 16 + 32 + 48;

   localparam logic [1:0] FUNC_SET = 2'd0;
   localparam logic [1:0] FUNC_DEL = 2'd1;
   localparam logic [1:0] FUNC_TRIG = 2'd2;

   localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] timer_id;
      logic [31:0] period_us;
      logic [47:0] now_us;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] fired_id;
      logic [47:0] next_delay_us;
      logic        queue_empty;
      logic        id_missing;
      logic        table_full;
      logic [4:0]  entries_in_use;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] id;
      logic [31:0] period;
      logic [47:0] deadline;
   } entry_type;

   // memory access from the sequencer
   typedef struct packed {
      logic            we;
      logic [IdxW-1:0] waddr;
      entry_type       wdata;
      logic [IdxW-1:0] raddr;
   } mem_req_type;

   function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [31:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {17'd0, b};
      return s[48] ? MAX48 : s[47:0];
   endfunction

endpackage

### rtl/core/stq_ram.sv
module stq_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### rtl/core/stq_seq.sv
`include "assert_macros.svh"
module stq_seq
   import stq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   output mem_req_type mem,
   input  entry_type   rdata
);
   // states; rdata comes from the RAM's registered read, so each read is issued before the step that uses it
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_FIND = 4'd1;  // scan for id
   localparam logic [3:0] S_RMV  = 4'd2;  // shift left from removed slot
   localparam logic [3:0] S_POS  = 4'd3;  // scan for insert position
   localparam logic [3:0] S_INS  = 4'd4;  // shift right from the top
   localparam logic [3:0] S_PUT  = 4'd5;
   localparam logic [3:0] S_SCAN = 4'd6;  // count expired entries at the head
   localparam logic [3:0] S_TAKE = 4'd7;  // take expired head out
   localparam logic [3:0] S_FIRE = 4'd8;
   localparam logic [3:0] S_STAT = 4'd9;  // read slot 0 for status
   localparam logic [3:0] S_OUT  = 4'd10;

   logic [3:0]      state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] ptr_ff, ptr_in;
   logic [CntW-1:0] dst_ff, dst_in;
   logic [CntW-1:0] fires_ff, fires_in;
   req_type         req_ff, req_in;
   entry_type       ins_ff, ins_in;
   logic            miss_ff, miss_in, full_ff, full_in;
   logic            ov_ff, ov_in;
   rsp_type         out_ff, out_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = ov_ff;
   assign rsp_data = out_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ptr_in = ptr_ff;
      dst_in = dst_ff;
      fires_in = fires_ff;
      req_in = req_ff;
      ins_in = ins_ff;
      miss_in = miss_ff;
      full_in = full_ff;
      ov_in = ov_ff && !rsp_ready;
      out_in = out_ff;
      mem = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               ins_in.id = req_data.timer_id;
               ins_in.period = req_data.period_us;
               ins_in.deadline = sat_add(req_data.now_us, req_data.period_us);
               miss_in = 1'b0;
               full_in = 1'b0;
               ptr_in = '0;
               fires_in = '0;
               case (req_data.func)
                  FUNC_SET, FUNC_DEL: state_in = S_FIND;
                  FUNC_TRIG: state_in = S_SCAN;
                  default: state_in = S_STAT;
               endcase
            end
         end
         S_FIND: begin
            // rdata is slot ptr_ff
            if (ptr_ff >= count_ff) begin
               if (req_ff.func == FUNC_DEL) begin
                  miss_in = 1'b1;
                  state_in = S_STAT;
               end else if (count_ff >= CntW'(TableDepth)) begin
                  full_in = 1'b1;
                  state_in = S_STAT;
               end else begin
                  ptr_in = '0;
                  state_in = S_POS;
               end
            end else if (rdata.id == req_ff.timer_id) begin
               // read the next slot to move it down
               ptr_in = ptr_ff + 1'b1;
               mem.raddr = IdxW'(ptr_ff + 1'b1);
               state_in = S_RMV;
            end else begin
               ptr_in = ptr_ff + 1'b1;
               mem.raddr = IdxW'(ptr_ff + 1'b1);
            end
         end
         S_RMV: begin
            // rdata is slot ptr_ff, goes to ptr_ff-1
            if (ptr_ff >= count_ff) begin
               count_in = count_ff - 1'b1;
               if (req_ff.func == FUNC_DEL) begin
                  state_in = S_STAT;
               end else begin
                  ptr_in = '0;
                  state_in = S_POS;
               end
            end else begin
               mem.we = 1'b1;
               mem.waddr = IdxW'(ptr_ff - 1'b1);
               mem.wdata = rdata;
               ptr_in = ptr_ff + 1'b1;
               mem.raddr = IdxW'(ptr_ff + 1'b1);
            end
         end
         S_POS: begin
            if (ptr_ff < count_ff && rdata.deadline <= ins_ff.deadline) begin
               ptr_in = ptr_ff + 1'b1;
               mem.raddr = IdxW'(ptr_ff + 1'b1);
            end else if (count_ff > ptr_ff) begin
               // insert at ptr_ff, shift from count-1 down
               dst_in = count_ff;
               mem.raddr = IdxW'(count_ff - 1'b1);
               state_in = S_INS;
            end else begin
               state_in = S_PUT;
            end
         end
         S_INS: begin
            // dst_ff is the destination slot, rdata its left neighbor
            mem.we = 1'b1;
            mem.waddr = IdxW'(dst_ff);
            mem.wdata = rdata;
            dst_in = dst_ff - 1'b1;
            if (dst_ff - 1'b1 > ptr_ff) begin
               mem.raddr = IdxW'(dst_ff - 2'd2);
            end else begin
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            mem.we = 1'b1;
            mem.waddr = IdxW'(ptr_ff);
            mem.wdata = ins_ff;
            count_in = count_ff + 1'b1;
            if (req_ff.func == FUNC_TRIG) begin
               state_in = S_FIRE;
            end else begin
               state_in = S_STAT;
            end
         end
         S_SCAN: begin
            // fires_ff ends as the number of expired entries at the head
            if (ptr_ff < count_ff && rdata.deadline <= req_ff.now_us) begin
               ptr_in = ptr_ff + 1'b1;
               mem.raddr = IdxW'(ptr_ff + 1'b1);
            end else if (ptr_ff == '0) begin
               state_in = S_STAT;
            end else begin
               fires_in = ptr_ff;
               state_in = S_TAKE;
            end
         end
         S_TAKE: begin
            // re-armed entry lands behind the remaining expired ones
            ins_in.id = rdata.id;
            ins_in.period = rdata.period;
            ins_in.deadline = sat_add(req_ff.now_us, rdata.period);
            ptr_in = CntW'(1);
            mem.raddr = IdxW'(1);
            state_in = S_RMV;
         end
         S_FIRE: begin
            if (!ov_ff || rsp_ready) begin
               out_in = '0;
               out_in.fired_id = ins_ff.id;
               out_in.entries_in_use = 5'(count_ff);
               ov_in = 1'b1;
               fires_in = fires_ff - 1'b1;
               if (fires_ff == CntW'(1)) begin
                  state_in = S_STAT;
               end else begin
                  state_in = S_TAKE;
               end
            end
         end
         S_STAT: state_in = S_OUT;
         S_OUT: begin
            if (!ov_ff || rsp_ready) begin
               out_in = '0;
               out_in.kind = 1'b1;
               out_in.last = 1'b1;
               out_in.queue_empty = (count_ff == '0);
               out_in.id_missing = miss_ff;
               out_in.table_full = full_ff;
               out_in.entries_in_use = 5'(count_ff);
               if (count_ff != '0 && rdata.deadline > req_ff.now_us) begin
                  out_in.next_delay_us = rdata.deadline - req_ff.now_us;
               end
               ov_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ov_ff <= ov_in;
      end
      ptr_ff <= ptr_in;
      dst_ff <= dst_in;
      fires_ff <= fires_in;
      req_ff <= req_in;
      ins_ff <= ins_in;
      miss_ff <= miss_in;
      full_ff <= full_in;
      out_ff <= out_in;
   end

   `ASSERT_IMPL(a_cnt_range, clock, reset, 1'b1, count_ff <= CntW'(TableDepth), "count over depth")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "item dropped")
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data), "item changed")
   `ASSERT_IMPL(a_ready_idle, clock, reset, req_ready, !mem.we, "write while idle")
endmodule

### rtl/core/sorted_timer_queue_core.sv
// Sorted deadline timer queue. Up to 16 periodic timers sit in one single-port-write,
// registered-read RAM in deadline order. A set scans for its id and removes an entry
// it finds by shifting the later ones down, then scans for the insert position, shifts
// and inserts; a delete scans and shifts down. A trigger takes each of its expired timers
// off the head and re-inserts it through the same scan. Time is set by the one RAM port
// and its registered read.
// One item at a time is in work; ready is high only while idle, and results wait in one
// output register while the receiver stalls, which holds the sequencer.
module sorted_timer_queue_core
   import stq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   mem_req_type mem;
   entry_type   rdata;
   logic [EntryW-1:0] rdata_raw;

   stq_ram #(.Width(EntryW), .Depth(TableDepth)) u_ram (
      .clock(clock), .we(mem.we), .waddr(mem.waddr), .wdata(mem.wdata),
      .raddr(mem.raddr), .rdata(rdata_raw)
   );
   assign rdata = entry_type'(rdata_raw);

   stq_seq u_seq (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .mem, .rdata
   );
endmodule
